>>> rtl/keyframe_path_interpolator_core_assert.svh
// Assertion helpers for the path interpolator core.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef KEYFRAME_PATH_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_PATH_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define KPI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kpi assertion failed");

// Next-cycle implication.
`define KPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kpi assertion failed");

`endif

>>> rtl/kpi_pkg.sv
`timescale 1ns / 1ps

package kpi_pkg;

    localparam logic signed [31:0] POS_RESET_DISTANCE = 32'sh0005_0000;
    localparam logic [15:0]        FPS_RESET          = 16'd3000;

    // Divider: 48-bit magnitude, four quotient bits per cycle.
    localparam int PROD_W     = 48;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = PROD_W / DIV_RADIX;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int SUM_W      = PROD_W + 2;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] point_distance;
        logic signed [31:0] point_angle_x;
        logic signed [31:0] point_angle_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic               add_rejected;
    } t_out;

    typedef struct packed {
        logic signed [31:0] distance;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
    } t_point;

    typedef enum logic [1:0] {
        COMP_DIST = 2'd0,
        COMP_AX   = 2'd1,
        COMP_AY   = 2'd2
    } t_comp;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_RDA  = 11'b000_0000_0010,
        ST_RDB  = 11'b000_0000_0100,
        ST_CAPB = 11'b000_0000_1000,
        ST_ONE  = 11'b000_0001_0000,
        ST_DIFF = 11'b000_0010_0000,
        ST_MUL  = 11'b000_0100_0000,
        ST_DIV  = 11'b000_1000_0000,
        ST_FIX  = 11'b001_0000_0000,
        ST_ADD  = 11'b010_0000_0000,
        ST_EMIT = 11'b100_0000_0000
    } t_state;

    function automatic logic signed [31:0] get_comp(input t_point p, input t_comp c);
        logic signed [31:0] v;
        unique case (c)
            COMP_DIST: v = p.distance;
            COMP_AX:   v = p.angle_x;
            COMP_AY:   v = p.angle_y;
            default:   v = p.distance;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/keyframe_path_interpolator_core.sv
`timescale 1ns / 1ps
// An append, or a tick with fewer than two points, gives its word without using the divider;
// a tick with two or more points makes three passes, one per component, through the shared
// multiply and radix-16 divide unit.
// Throughput: one word at a time; the next word is taken the cycle after the result loads.
// Reset (synchronous, active low) clears the point count, frame and segment counters, sets
// the position to distance 5.0 and the segment length to 3000; the point table is not reset.
module keyframe_path_interpolator_core
    import kpi_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

`include "keyframe_path_interpolator_core_assert.svh"

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = $clog2(MAX_POINTS);

    t_state                 r_state, n_state;
    logic [15:0]            r_fps;
    logic [CW-1:0]          r_count;
    logic [15:0]            r_frame;
    logic [SW-1:0]          r_seg;
    logic [SW-1:0]          r_sel;
    logic [15:0]            r_n;
    t_point                 r_pos;
    logic                   r_rej;
    t_point                 r_mem [MAX_POINTS];
    t_point                 r_rdata;
    t_point                 r_a, r_b;
    t_comp                  r_comp;
    logic                   r_neg;
    logic [31:0]            r_mag;
    logic [PROD_W-1:0]      r_dvd;
    logic [15:0]            r_rem;
    logic [STEP_W-1:0]      r_step;
    logic signed [SUM_W-1:0] r_q;
    logic                   r_out_valid;
    t_out                   r_out;

    logic                   in_acc;
    logic                   add_ok;
    logic                   slot_free;
    logic [SW-1:0]          rd_addr;
    logic signed [31:0]     a_c, b_c;
    logic signed [32:0]     d_ba, d_ab;
    logic [PROD_W-1:0]      n_dvd;
    logic [15:0]            n_rem;
    logic signed [SUM_W-1:0] q_ext, sum;
    logic signed [31:0]     sat_val;
    logic [16:0]            frame_inc;
    logic                   seg_wrap;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign add_ok      = in_acc && i_in_data.mode == MODE_ADD && r_count < CW'(MAX_POINTS);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rd_addr = (r_state == ST_RDB) ? r_sel + SW'(1) : r_sel;
    assign a_c     = get_comp(r_a, r_comp);
    assign b_c     = get_comp(r_b, r_comp);
    assign d_ba    = 33'(b_c) - 33'(a_c);
    assign d_ab    = 33'(a_c) - 33'(b_c);

    // Four restoring-division steps per cycle; the dividend register collects the quotient.
    always_comb begin
        logic [16:0]       trial;
        logic              qbit;
        logic [PROD_W-1:0] dvd;
        logic [15:0]       rem;
        dvd = r_dvd;
        rem = r_rem;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial = {rem, dvd[PROD_W-1]};
            qbit  = (trial >= {1'b0, r_n});
            dvd   = {dvd[PROD_W-2:0], qbit};
            rem   = qbit ? 16'(trial - {1'b0, r_n}) : trial[15:0];
        end
        n_dvd = dvd;
        n_rem = rem;
    end

    assign q_ext = {2'b00, r_dvd};
    assign sum   = SUM_W'(a_c) + r_q;

    always_comb begin
        if (sum[SUM_W-1:31] == '0 || sum[SUM_W-1:31] == '1) begin
            sat_val = sum[31:0];
        end else if (sum[SUM_W-1]) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = 32'sh7FFF_FFFF;
        end
    end

    assign frame_inc = 17'(r_frame) + 17'd1;
    assign seg_wrap  = ((CW+1)'(r_sel) + (CW+1)'(2)) >= (CW+1)'(r_count);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.mode == MODE_ADD || r_count == '0) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_RDA;
                    end
                end
            end
            ST_RDA:  n_state = (r_count == CW'(1)) ? ST_ONE : ST_RDB;
            ST_RDB:  n_state = ST_CAPB;
            ST_CAPB: n_state = ST_DIFF;
            ST_ONE:  n_state = ST_EMIT;
            ST_DIFF: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  n_state = (r_step == STEP_W'(DIV_STEPS - 1)) ? ST_FIX : ST_DIV;
            ST_FIX:  n_state = ST_ADD;
            ST_ADD:  n_state = (r_comp == COMP_AY) ? ST_EMIT : ST_DIFF;
            ST_EMIT: n_state = slot_free ? ST_IDLE : ST_EMIT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            r_mem[r_count[SW-1:0]] <= '{i_in_data.point_distance,
                                        i_in_data.point_angle_x,
                                        i_in_data.point_angle_y};
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fps       <= FPS_RESET;
            r_count     <= '0;
            r_frame     <= '0;
            r_seg       <= '0;
            r_pos       <= '{POS_RESET_DISTANCE, 32'sd0, 32'sd0};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_fps <= i_cfg_wdata;
            end
            if (r_state == ST_EMIT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (add_ok) begin
                r_count <= r_count + CW'(1);
            end
            if (r_state == ST_ONE) begin
                r_pos <= r_rdata;
            end
            if (r_state == ST_ADD) begin
                case (r_comp)
                    COMP_DIST: r_pos.distance <= sat_val;
                    COMP_AX:   r_pos.angle_x  <= sat_val;
                    default:   r_pos.angle_y  <= sat_val;
                endcase
                if (r_comp == COMP_AY) begin
                    // The counters move only after all three components are done.
                    if (frame_inc >= 17'(r_n)) begin
                        r_frame <= '0;
                        r_seg   <= seg_wrap ? '0 : r_sel + SW'(1);
                    end else begin
                        r_frame <= frame_inc[15:0];
                        r_seg   <= r_sel;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rej  <= (i_in_data.mode == MODE_ADD) && (r_count >= CW'(MAX_POINTS));
                r_n    <= (r_fps == '0) ? 16'd1 : r_fps;
                r_comp <= COMP_DIST;
                if (r_count < CW'(2) ||
                    (CW+1)'(r_seg) + (CW+1)'(1) >= (CW+1)'(r_count)) begin
                    r_sel <= '0;
                end else begin
                    r_sel <= r_seg;
                end
            end
            ST_RDB:  r_a <= r_rdata;
            ST_CAPB: r_b <= r_rdata;
            ST_DIFF: begin
                r_neg <= d_ba[32];
                r_mag <= d_ba[32] ? d_ab[31:0] : d_ba[31:0];
            end
            ST_MUL: begin
                r_dvd  <= PROD_W'(r_mag) * PROD_W'(r_frame);
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_dvd  <= n_dvd;
                r_rem  <= n_rem;
                r_step <= r_step + STEP_W'(1);
            end
            ST_FIX: begin
                // Floor of a negative quotient: -(Q + 1) when a remainder is left, else -Q.
                if (!r_neg) begin
                    r_q <= q_ext;
                end else if (r_rem != '0) begin
                    r_q <= ~q_ext;
                end else begin
                    r_q <= -q_ext;
                end
            end
            ST_ADD: begin
                if (r_comp == COMP_DIST) begin
                    r_comp <= COMP_AX;
                end else begin
                    r_comp <= COMP_AY;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    r_out <= '{r_pos.distance, r_pos.angle_x, r_pos.angle_y, r_rej};
                end
            end
            default: begin
            end
        endcase
    end

    `KPI_ASSERT_NEXT(a_count_grows, add_ok, r_count == $past(r_count) + CW'(1))
    `KPI_ASSERT_SAME(a_seg_valid, r_count >= CW'(2), CW'(r_seg) < r_count - CW'(1))
    `KPI_ASSERT_SAME(a_div_bound, r_state == ST_DIV, r_step < STEP_W'(DIV_STEPS))
    `KPI_ASSERT_NEXT(a_emit_loads, r_state == ST_EMIT && slot_free, o_out_valid && r_state == ST_IDLE)

endmodule
